// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and defaults for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // default number of cells in the queue
    localparam int unsigned QueueDepthDefault = 16;

    localparam int unsigned LevelW = 2;
    localparam int unsigned TagW   = 16;

    // operation codes on the mode field
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // input item
    typedef struct packed {
        logic              mode;
        logic [TagW-1:0]   item_tag;
        logic [LevelW-1:0] priority_req;
    } spq_in_t;

    // result item
    typedef struct packed {
        logic [1:0]        status;
        logic [TagW-1:0]   out_tag;
        logic [LevelW-1:0] out_priority;
    } spq_out_t;

    // one stored entry
    typedef struct packed {
        logic [LevelW-1:0] level;
        logic [TagW-1:0]   tag;
    } spq_entry_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic       push;
        logic       pop;
        spq_entry_t entry;
    } spq_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One position of the sorted queue. On a push it keeps its entry, takes the
// new one or takes its left neighbour's; on a pop it takes its right
// neighbour's.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::spq_ctrl_t ctrl_i,
    input  logic               occupied_i,
    input  logic               left_keep_i,
    input  spq_pkg::spq_entry_t left_i,
    input  spq_pkg::spq_entry_t right_i,
    output logic               keep_o,
    output spq_pkg::spq_entry_t entry_o
);

    spq_pkg::spq_entry_t entry_reg;
    spq_pkg::spq_entry_t entry_next;

    // entry stays put when it is served no later than the new one
    assign keep_o = occupied_i && (entry_reg.level <= ctrl_i.entry.level);

    // next entry from the neighbours or the new item
    always_comb begin
        entry_next = entry_reg;
        if (ctrl_i.push && !keep_o) begin
            if (left_keep_i) begin
                entry_next = ctrl_i.entry;
            end else begin
                entry_next = left_i;
            end
        end else if (ctrl_i.pop) begin
            entry_next = right_i;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_o = entry_reg;

endmodule

// ===== rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded stable priority queue built as a row of cells sorted by level,
// head in cell 0. Pushes insert behind all entries of equal or better level.
// ----------------------------------------------------------------------------
//  channel   ports                      direction  payload
//  input     s_valid s_ready s_data     in         spq_in_t  (mode, tag, level)
//  result    m_valid m_ready m_data     out        spq_out_t (status, tag, level)
//
//  one item per cycle while results are taken: every cell compares and
//  shifts in the same cycle, and the result is registered on acceptance.
//  reset clears the entry count and the output valid; cell contents are
//  left as they are. a stalled result holds the input only while the output
//  register is still full and not being taken.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spq_pkg::spq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output spq_pkg::spq_out_t m_data
);

    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    spq_pkg::spq_out_t   m_data_reg;
    spq_pkg::spq_out_t   m_data_next;

    logic                accept;
    logic                full;
    logic                empty;
    spq_pkg::spq_ctrl_t  ctrl;

    logic                keep   [QUEUE_DEPTH];
    spq_pkg::spq_entry_t entries[QUEUE_DEPTH];

    // handshake and queue state
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);

    // operation broadcast to the cells
    always_comb begin
        ctrl.push         = accept && (s_data.mode == spq_pkg::OP_PUSH) && !full;
        ctrl.pop          = accept && (s_data.mode == spq_pkg::OP_POP) && !empty;
        ctrl.entry.level  = s_data.priority_req;
        ctrl.entry.tag    = s_data.item_tag;
    end

    // row of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                occupied;
        logic                left_keep;
        spq_pkg::spq_entry_t left_entry;
        spq_pkg::spq_entry_t right_entry;

        assign occupied = (CntW'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_entry = ctrl.entry;
        end else begin : g_body
            assign left_keep  = keep[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_entry = entries[i];
        end else begin : g_inner
            assign right_entry = entries[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl_i      (ctrl),
            .occupied_i  (occupied),
            .left_keep_i (left_keep),
            .left_i      (left_entry),
            .right_i     (right_entry),
            .keep_o      (keep[i]),
            .entry_o     (entries[i])
        );
    end

    // entry count and result
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next             = 1'b1;
            m_data_next.out_tag      = '0;
            m_data_next.out_priority = '0;
            if (s_data.mode == spq_pkg::OP_PUSH) begin
                if (full) begin
                    m_data_next.status = spq_pkg::ST_FULL;
                end else begin
                    m_data_next.status = spq_pkg::ST_PUSHED;
                    count_next         = count_reg + CntW'(1);
                end
            end else begin
                if (empty) begin
                    m_data_next.status = spq_pkg::ST_EMPTY;
                end else begin
                    m_data_next.status       = spq_pkg::ST_POPPED;
                    m_data_next.out_tag      = entries[0].tag;
                    m_data_next.out_priority = entries[0].level;
                    count_next               = count_reg - CntW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== bench/tb_stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking bench for the stable priority queue. A shadow sorted list
// predicts the result of every accepted item, and the monitor compares each
// result field by field with the oldest prediction. The run starts with a
// short directed sequence: pop on empty, a full fill, push on full, then
// pops. It goes on with random fill and drain phases. Both channels idle
// at random.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;

    localparam int unsigned QueueDepth  = spq_pkg::QueueDepthDefault;
    localparam int unsigned LevelW      = spq_pkg::LevelW;
    localparam int unsigned TagW        = spq_pkg::TagW;
    localparam int          RandomItems = 1550;
    localparam int          DrainCycles = 20;
    localparam int          CycleLimit  = 300000;
    localparam int          ReportLimit = 10;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    spq_pkg::spq_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    spq_pkg::spq_out_t m_data;

    stable_priority_queue #(
        .QUEUE_DEPTH (QueueDepth)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    always #5 aclk = ~aclk;

    // shadow copy of the sorted list, head at index 0
    logic [LevelW-1:0] shadow_level [QueueDepth];
    logic [TagW-1:0]   shadow_tag   [QueueDepth];
    int unsigned       shadow_count = 0;

    spq_pkg::spq_in_t  ops_to_send [$];
    spq_pkg::spq_out_t results_due [$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int n_pushed       = 0;
    int n_popped       = 0;
    int n_empty        = 0;
    int n_dropped      = 0;

    // work out the result of one operation and update the shadow list
    function automatic spq_pkg::spq_out_t apply_queue_op(spq_pkg::spq_in_t op);
        spq_pkg::spq_out_t res;
        int unsigned       pos;
        res = '0;
        if (op.mode == spq_pkg::OP_PUSH) begin
            if (shadow_count >= QueueDepth) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                // insert behind every entry of equal or better level
                pos = 0;
                while (pos < shadow_count && shadow_level[pos] <= op.priority_req)
                    pos++;
                for (int i = int'(shadow_count); i > int'(pos); i--) begin
                    shadow_level[i] = shadow_level[i-1];
                    shadow_tag[i]   = shadow_tag[i-1];
                end
                shadow_level[pos] = op.priority_req;
                shadow_tag[pos]   = op.item_tag;
                shadow_count++;
                res.status = spq_pkg::ST_PUSHED;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.status       = spq_pkg::ST_POPPED;
                res.out_tag      = shadow_tag[0];
                res.out_priority = shadow_level[0];
                for (int i = 1; i < int'(shadow_count); i++) begin
                    shadow_level[i-1] = shadow_level[i];
                    shadow_tag[i-1]   = shadow_tag[i];
                end
                shadow_count--;
            end
        end
        return res;
    endfunction

    function automatic spq_pkg::spq_in_t make_op(logic mode, logic [TagW-1:0] tag,
                                                 logic [LevelW-1:0] level);
        spq_pkg::spq_in_t op;
        op.mode         = mode;
        op.item_tag     = tag;
        op.priority_req = level;
        return op;
    endfunction

    // input driver: bursts of items separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive_items
        logic             nxt_valid;
        spq_pkg::spq_in_t nxt_data;
        nxt_valid = s_valid;
        nxt_data  = s_data;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            // item taken at this edge: predict its result
            if (s_valid && s_ready) begin
                results_due.push_back(apply_queue_op(s_data));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (ops_to_send.size() != 0) begin
                    nxt_data  = ops_to_send.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(60, 200);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = $urandom_range(0, 7);
                    end
                end
            end
        end
        s_valid <= nxt_valid;
        s_data  <= nxt_data;
    end

    // result receiver: always ready, a repeating stall pattern, or random
    int          ready_style = 0;
    int          style_left  = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_phase   = '0;

    always @(posedge aclk) begin : drive_ready
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (aresetn) begin
            if (style_left == 0) begin
                ready_style   = $urandom_range(0, 2);
                style_left    = $urandom_range(20, 150);
                stall_pattern = 16'($urandom) | 16'h0001;
            end else begin
                style_left--;
            end
            stall_phase = stall_phase + 4'd1;
            case (ready_style)
                0: nxt_ready = 1'b1;
                1: nxt_ready = stall_pattern[stall_phase];
                default: nxt_ready = ($urandom_range(0, 3) != 0);
            endcase
        end
        m_ready <= nxt_ready;
    end

    // result monitor
    always @(posedge aclk) begin : check_results
        spq_pkg::spq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            case (m_data.status)
                spq_pkg::ST_PUSHED: n_pushed++;
                spq_pkg::ST_POPPED: n_popped++;
                spq_pkg::ST_EMPTY:  n_empty++;
                default:            n_dropped++;
            endcase
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= ReportLimit)
                    $display("unexpected result: status %0d tag %h level %0d",
                             m_data.status, m_data.out_tag, m_data.out_priority);
            end else begin
                want = results_due.pop_front();
                if (m_data.status !== want.status || m_data.out_tag !== want.out_tag ||
                    m_data.out_priority !== want.out_priority) begin
                    mismatch_count++;
                    if (mismatch_count <= ReportLimit)
                        $display("mismatch: expected status %0d tag %h level %0d, ",
                                 want.status, want.out_tag, want.out_priority,
                                 "got status %0d tag %h level %0d",
                                 m_data.status, m_data.out_tag, m_data.out_priority);
                end
            end
        end
    end

    // cycle counter and watchdog
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    // stimulus and end of run
    initial begin : run_sequence
        logic [TagW-1:0] fill_tags [16];
        int              made;
        int              seg_len;
        int              push_pct;
        int              fixed_level;
        fill_tags = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555,
                      16'h7FFF, 16'hFFFE, 16'h1234, 16'h0F0F, 16'hF0F0, 16'h00FF,
                      16'hFF00, 16'h3C3C, 16'hC3C3, 16'h0002};

        // directed: pop on empty, fill with mixed levels, push on full, pops
        ops_to_send.push_back(make_op(spq_pkg::OP_POP, 16'hFFFF, 2'd3));
        for (int i = 0; i < 16; i++)
            ops_to_send.push_back(make_op(spq_pkg::OP_PUSH, fill_tags[i],
                                          LevelW'((i * 3) % 4)));
        ops_to_send.push_back(make_op(spq_pkg::OP_PUSH, 16'hFFFF, 2'd0));
        for (int i = 0; i < 6; i++)
            ops_to_send.push_back(make_op(spq_pkg::OP_POP, 16'(i * 16'h1111),
                                          LevelW'(i)));

        // random: fill-heavy, balanced and drain-heavy phases
        made = 0;
        while (made < RandomItems) begin
            seg_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 50;
                default: push_pct = 15;
            endcase
            // some phases use one level only, to stress first-in first-out order
            fixed_level = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3)) : -1;
            for (int i = 0; i < seg_len && made < RandomItems; i++) begin
                ops_to_send.push_back(make_op(
                    ($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH
                                                       : spq_pkg::OP_POP,
                    16'($urandom_range(0, 65535)),
                    (fixed_level < 0) ? LevelW'($urandom_range(0, 3))
                                      : LevelW'(fixed_level)));
                made++;
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_to_send.size() != 0 || s_valid) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("run covered %0d pushes, %0d valid pops, ", n_pushed, n_popped,
                 "%0d pops on empty, %0d pushes on full", n_empty, n_dropped);
        $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
bench/tb_stable_priority_queue.sv
